// ----- src/utf8v_pkg.sv -----
`timescale 1ns / 1ps

package utf8v_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 8;
    localparam int unsigned AccW   = 21;

    localparam logic [CountW-1:0] MaxCharsReset = 8'd64;

    localparam logic [AccW-1:0] Min3Byte    = 21'h000800;
    localparam logic [AccW-1:0] Min4Byte    = 21'h010000;
    localparam logic [AccW-1:0] SurrLow     = 21'h00D800;
    localparam logic [AccW-1:0] SurrHigh    = 21'h00DFFF;
    localparam logic [AccW-1:0] MaxCodePnt  = 21'h10FFFF;

    // continuation counts that tag the length of the open character
    localparam logic [1:0] SeqOne   = 2'd0;
    localparam logic [1:0] SeqTwo   = 2'd1;
    localparam logic [1:0] SeqThree = 2'd2;
    localparam logic [1:0] SeqFour  = 2'd3;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_LEAD  = 3'd1,
        ERR_CONT  = 3'd2,
        ERR_TRUNC = 3'd3,
        ERR_POINT = 3'd4,
        ERR_LONG  = 3'd5
    } err_t;

    typedef struct packed {
        logic [1:0]        pending;
        logic [1:0]        seq_len;
        logic [AccW-1:0]   acc;
        logic [CountW-1:0] count;
        err_t              err;
    } state_t;

    // lowest bit up: string_valid, fail_reason, character_count
    typedef struct packed {
        logic [CountW-1:0] character_count;
        logic [2:0]        fail_reason;
        logic              string_valid;
    } result_t;

    localparam int unsigned ResultW = $bits(result_t);
    localparam int unsigned TdataW  = ((ResultW + 7) / 8) * 8;

endpackage

// ----- src/utf8v_step.sv -----
`timescale 1ns / 1ps

module utf8v_step (
    input  utf8v_pkg::state_t              state_cur,
    input  logic [utf8v_pkg::ByteW-1:0]    data_byte,
    input  logic                           byte_present,
    input  logic                           last_byte,
    input  logic [utf8v_pkg::CountW-1:0]   max_chars,
    output utf8v_pkg::state_t              state_next,
    output logic                           result_valid,
    output utf8v_pkg::result_t             result
);

    utf8v_pkg::state_t st;
    logic              do_finish;
    logic              bad_point;

    always_comb begin
        st        = state_cur;
        do_finish = 1'b0;
        bad_point = 1'b0;

        if (byte_present && (state_cur.err == utf8v_pkg::ERR_NONE)) begin
            if (state_cur.pending == 2'd0) begin
                case (data_byte) inside
                    [8'h00:8'h7F]: begin
                        st.seq_len = utf8v_pkg::SeqOne;
                        st.acc     = {13'd0, data_byte};
                        do_finish  = 1'b1;
                    end
                    [8'hC2:8'hDF]: begin
                        st.seq_len = utf8v_pkg::SeqTwo;
                        st.pending = 2'd1;
                        st.acc     = {16'd0, data_byte[4:0]};
                    end
                    [8'hE0:8'hEF]: begin
                        st.seq_len = utf8v_pkg::SeqThree;
                        st.pending = 2'd2;
                        st.acc     = {17'd0, data_byte[3:0]};
                    end
                    [8'hF0:8'hF4]: begin
                        st.seq_len = utf8v_pkg::SeqFour;
                        st.pending = 2'd3;
                        st.acc     = {18'd0, data_byte[2:0]};
                    end
                    default: begin
                        st.err = utf8v_pkg::ERR_LEAD;
                    end
                endcase
            end else if (data_byte[7:6] != 2'b10) begin
                st.err = utf8v_pkg::ERR_CONT;
            end else begin
                st.acc     = {state_cur.acc[utf8v_pkg::AccW-7:0], data_byte[5:0]};
                st.pending = state_cur.pending - 2'd1;
                do_finish  = (state_cur.pending == 2'd1);
            end
        end

        // code point checks once the character is complete
        bad_point = ((st.seq_len == utf8v_pkg::SeqThree) && (st.acc < utf8v_pkg::Min3Byte))
                 || ((st.seq_len == utf8v_pkg::SeqFour) && (st.acc < utf8v_pkg::Min4Byte))
                 || ((st.acc >= utf8v_pkg::SurrLow) && (st.acc <= utf8v_pkg::SurrHigh))
                 || (st.acc > utf8v_pkg::MaxCodePnt);

        if (do_finish) begin
            if (bad_point) begin
                st.err = utf8v_pkg::ERR_POINT;
            end else if (st.count >= max_chars) begin
                st.err = utf8v_pkg::ERR_LONG;
            end else begin
                st.count = st.count + 8'd1;
            end
        end

        if (last_byte && (st.err == utf8v_pkg::ERR_NONE) && (st.pending != 2'd0)) begin
            st.err = utf8v_pkg::ERR_TRUNC;
        end
    end

    assign result_valid           = last_byte;
    assign result.string_valid    = (st.err == utf8v_pkg::ERR_NONE);
    assign result.fail_reason     = st.err;
    assign result.character_count = st.count;

    // a verdict closes the string
    assign state_next = last_byte ? '{pending: 2'd0, seq_len: 2'd0, acc: '0, count: '0,
                                      err: utf8v_pkg::ERR_NONE}
                                  : st;

endmodule

// ----- src/utf8v_out_buf.sv -----
`timescale 1ns / 1ps

module utf8v_out_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  utf8v_pkg::result_t in_data,
    output logic               in_ready,
    output logic               out_valid,
    output utf8v_pkg::result_t out_data,
    input  logic               out_ready
);

    logic               main_valid_reg, main_valid_next;
    utf8v_pkg::result_t main_reg, main_next;
    logic               skid_valid_reg, skid_valid_next;
    utf8v_pkg::result_t skid_reg, skid_next;
    logic               main_free;

    assign main_free = !main_valid_reg || out_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (main_free) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = in_valid;
                main_next       = in_data;
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

// ----- src/utf8_validate_with_char_limit_unit.sv -----
`timescale 1ns / 1ps

// Strict UTF-8 validator with a character limit. Bytes of a string arrive one per
// transaction on the s_ side, the final one with s_tlast; an empty string is a single
// transaction with s_tuser low (no byte) and s_tlast high. One verdict transaction per
// string comes out on the m_ side: string_valid, fail_reason (0 ok, 1 bad lead,
// 2 bad continuation, 3 truncated, 4 bad code point, 5 too long) and the number of
// characters decoded before the end or the first error. The first error wins and the
// rest of the string is only scanned for its end. Throughput is one byte per clock
// while the result buffer has room: the decode state is updated by one pass of logic
// per byte, and the verdict is registered in the buffer. A two-entry result buffer lets
// input keep flowing while a verdict waits; s_tready drops only when both entries are
// held. max_characters sits at APB address 0 (reset 64) and is to be written only while
// no string is in flight; the block itself does not enforce this.

module utf8_validate_with_char_limit_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // last_byte
    // verdict output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [utf8v_pkg::TdataW-1:0] m_tdata,
        // [0] string_valid, [3:1] fail_reason, [11:4] character_count, rest zero
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [utf8v_pkg::CountW-1:0] max_chars_reg;
    utf8v_pkg::state_t            state_reg;
    utf8v_pkg::state_t            state_next;
    logic                         s_xfer;
    logic                         res_valid;
    utf8v_pkg::result_t           res_data;
    logic                         res_ready;
    utf8v_pkg::result_t           out_data;
    logic                         cfg_wr;

    // ---- register port ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {24'd0, max_chars_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chars_reg <= utf8v_pkg::MaxCharsReset;
        end else if (cfg_wr) begin
            max_chars_reg <= pwdata[7:0];
        end
    end

    // ---- per-byte decode ----
    assign s_tready = res_ready;
    assign s_xfer   = s_tvalid && s_tready;

    utf8v_step u_step (
        .state_cur    (state_reg),
        .data_byte    (s_tdata),
        .byte_present (s_tuser),
        .last_byte    (s_tlast),
        .max_chars    (max_chars_reg),
        .state_next   (state_next),
        .result_valid (res_valid),
        .result       (res_data)
    );

    // decode state only moves on an accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{pending: 2'd0, seq_len: 2'd0, acc: '0, count: '0,
                           err: utf8v_pkg::ERR_NONE};
        end else if (s_xfer) begin
            state_reg <= state_next;
        end
    end

    // ---- verdict buffer ----
    utf8v_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_xfer && res_valid),
        .in_data   (res_data),
        .in_ready  (res_ready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_ready (m_tready)
    );

    assign m_tdata = {{(utf8v_pkg::TdataW - utf8v_pkg::ResultW){1'b0}}, out_data};

`ifndef SYNTHESIS
    // after a string end m_tvalid is high on the next cycle, possibly with an older verdict
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("verdict missing after string end");

    // a verdict leaves the decoder clean for the next string
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=>
            (state_reg.err == utf8v_pkg::ERR_NONE) && (state_reg.pending == 2'd0)
            && (state_reg.count == '0))
        else $error("decode state not cleared after verdict");

    // the first error sticks until the string ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg.err != utf8v_pkg::ERR_NONE) && !(s_tvalid && s_tready && s_tlast))
            |=> (state_reg.err == $past(state_reg.err)))
        else $error("first error overwritten mid-string");

    // pending continuations never exceed the length of the open character
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pending <= state_reg.seq_len)
        else $error("pending continuation count out of range");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

class verdict_scoreboard;
    logic [7:0]           max_chars;
    logic [1:0]           open_conts;
    logic [1:0]           char_len;
    logic [20:0]          code_point;
    logic [7:0]           char_count;
    utf8v_pkg::err_t      first_fault;
    utf8v_pkg::result_t   verdicts_due[$];
    int                   errors;
    int                   reason_seen[6];

    function new();
        max_chars = utf8v_pkg::MaxCharsReset;
        errors = 0;
        foreach (reason_seen[i]) reason_seen[i] = 0;
        clear_string();
    endfunction

    function void clear_string();
        open_conts  = '0;
        char_len    = '0;
        code_point  = '0;
        char_count  = '0;
        first_fault = utf8v_pkg::ERR_NONE;
    endfunction

    // a complete character sits in code_point
    function void close_char();
        if ((char_len == utf8v_pkg::SeqThree && code_point < utf8v_pkg::Min3Byte) ||
            (char_len == utf8v_pkg::SeqFour && code_point < utf8v_pkg::Min4Byte) ||
            (code_point >= utf8v_pkg::SurrLow && code_point <= utf8v_pkg::SurrHigh) ||
            code_point > utf8v_pkg::MaxCodePnt) begin
            first_fault = utf8v_pkg::ERR_POINT;
        end else if (char_count >= max_chars) begin
            first_fault = utf8v_pkg::ERR_LONG;
        end else begin
            char_count = char_count + 8'd1;
        end
    endfunction

    function void take_item(logic [7:0] b, logic present, logic last);
        utf8v_pkg::result_t verdict;
        if (present && first_fault == utf8v_pkg::ERR_NONE) begin
            if (open_conts == 2'd0) begin
                if (b < 8'h80) begin
                    char_len   = utf8v_pkg::SeqOne;
                    code_point = {13'd0, b};
                    close_char();
                end else if (b >= 8'hC2 && b <= 8'hDF) begin
                    char_len   = utf8v_pkg::SeqTwo;
                    open_conts = 2'd1;
                    code_point = {16'd0, b[4:0]};
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    char_len   = utf8v_pkg::SeqThree;
                    open_conts = 2'd2;
                    code_point = {17'd0, b[3:0]};
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    char_len   = utf8v_pkg::SeqFour;
                    open_conts = 2'd3;
                    code_point = {18'd0, b[2:0]};
                end else begin
                    first_fault = utf8v_pkg::ERR_LEAD;
                end
            end else if (b[7:6] != 2'b10) begin
                first_fault = utf8v_pkg::ERR_CONT;
            end else begin
                code_point = {code_point[14:0], b[5:0]};
                open_conts = open_conts - 2'd1;
                if (open_conts == 2'd0) close_char();
            end
        end
        if (!last) return;
        if (first_fault == utf8v_pkg::ERR_NONE && open_conts != 2'd0)
            first_fault = utf8v_pkg::ERR_TRUNC;
        verdict.string_valid    = (first_fault == utf8v_pkg::ERR_NONE);
        verdict.fail_reason     = first_fault;
        verdict.character_count = char_count;
        verdicts_due.insert(verdicts_due.size(), verdict);
        clear_string();
    endfunction

    function void report(string field, int want, int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_verdict(logic [utf8v_pkg::TdataW-1:0] tdata);
        utf8v_pkg::result_t got;
        utf8v_pkg::result_t want;
        got = tdata[utf8v_pkg::ResultW-1:0];
        if (verdicts_due.size() == 0) begin
            errors++;
            $display("%0t: verdict %h with none expected", $time, tdata);
            return;
        end
        want = verdicts_due.pop_front();
        reason_seen[want.fail_reason]++;
        if (got.string_valid !== want.string_valid)
            report("string_valid", want.string_valid, got.string_valid);
        if (got.fail_reason !== want.fail_reason)
            report("fail_reason", want.fail_reason, got.fail_reason);
        if (got.character_count !== want.character_count)
            report("character_count", want.character_count, got.character_count);
        if (tdata[utf8v_pkg::TdataW-1:utf8v_pkg::ResultW] !== '0)
            report("tdata padding", 0, tdata[utf8v_pkg::TdataW-1:utf8v_pkg::ResultW]);
    endfunction
endclass

module testbench;

    localparam int          CycleLimit   = 400000;
    localparam int          ByteTarget   = 1850;
    localparam int          NumPhases    = 7;
    localparam logic [2:0]  MaxCharsAddr = 3'd0;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } byte_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [utf8v_pkg::TdataW-1:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    verdict_scoreboard sb = new();

    byte_item_t string_bytes[$];  // string under construction
    int         bytes_sent  = 0;
    int         cycle_count = 0;
    int         rx_hold     = 0;  // receiver hold-off cycles still to go
    bit         steady      = 1'b0; // no idling on either side

    utf8_validate_with_char_limit_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] data_byte
        .s_tuser  (s_tuser),   // [0] byte_present
        .s_tlast  (s_tlast),   // last_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [0] string_valid, [3:1] fail_reason, [11:4] character_count
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: check accepted verdicts, then decide the next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_verdict(m_tdata);
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 28);
        end
    end

    // offer one byte transaction and wait for the handshake, with random gaps first unless steady
    task automatic send_item(input logic [7:0] b, input logic present, input logic last);
        if (!steady) begin
            while ($urandom_range(0, 99) < 28) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= present;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_item(b, present, last);
        bytes_sent++;
    endtask

    task automatic send_string();
        foreach (string_bytes[i])
            send_item(string_bytes[i].data, string_bytes[i].present, string_bytes[i].last);
        string_bytes.delete();
    endtask

    // stop offering and let every verdict drain out of the block
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.verdicts_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // setup then access phase; a read compares against the predicted register
    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (wr) begin
            sb.max_chars = data[7:0];
        end else if (prdata[7:0] !== sb.max_chars) begin
            sb.errors++;
            $display("%0t: max_characters readback, expected %0d, actual %0d",
                     $time, sb.max_chars, prdata[7:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void add_byte(logic [7:0] b);
        // now and then an ignored transaction with no byte
        if ($urandom_range(0, 99) < 3)
            string_bytes.insert(string_bytes.size(),
                '{data: 8'($urandom_range(0, 255)), present: 1'b0, last: 1'b0});
        string_bytes.insert(string_bytes.size(), '{data: b, present: 1'b1, last: 1'b0});
    endfunction

    // encode a code point in a forced number of bytes (may be overlong)
    function automatic void add_char(logic [20:0] cp, int nbytes);
        case (nbytes)
            1: add_byte({1'b0, cp[6:0]});
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic void add_valid_char();
        case ($urandom_range(1, 4))
            1: add_char(21'($urandom_range(0, 'h7F)), 1);
            2: add_char(21'($urandom_range('h80, 'h7FF)), 2);
            3: begin
                if ($urandom_range(0, 1) == 0) add_char(21'($urandom_range('h800, 'hD7FF)), 3);
                else add_char(21'($urandom_range('hE000, 'hFFFF)), 3);
            end
            default: add_char(21'($urandom_range('h10000, 'h10FFFF)), 4);
        endcase
    endfunction

    // overlong forms, surrogates and code points past the top of the range
    function automatic void add_bad_char();
        case ($urandom_range(0, 4))
            0: add_char(21'($urandom_range(0, 'h7F)), 2);
            1: add_char(21'($urandom_range(0, 'h7FF)), 3);
            2: add_char(21'($urandom_range(0, 'hFFFF)), 4);
            3: add_char(21'($urandom_range('hD800, 'hDFFF)), 3);
            default: add_char(21'($urandom_range('h110000, 'h1FFFFF)), 4);
        endcase
    endfunction

    function automatic void end_string();
        if (string_bytes.size() == 0 || $urandom_range(0, 99) < 12)
            string_bytes.insert(string_bytes.size(),
                '{data: 8'($urandom_range(0, 255)), present: 1'b0, last: 1'b1});
        else
            string_bytes[string_bytes.size()-1].last = 1'b1;
    endfunction

    // mostly well-formed strings, some with one defect, a few pure noise
    function automatic void build_random_string();
        int nchars;
        int mode;
        int bad_at;
        int idx;
        if (sb.max_chars <= 20 && $urandom_range(0, 3) == 0)
            nchars = sb.max_chars + $urandom_range(0, 1);
        else
            nchars = $urandom_range(0, 8);
        mode   = $urandom_range(0, 99);
        bad_at = (mode >= 65 && mode < 72) ? $urandom_range(0, nchars) : -1;
        if (mode >= 92) begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
        end else begin
            for (int i = 0; i <= nchars; i++) begin
                if (i == bad_at) add_bad_char();
                if (i < nchars) add_valid_char();
            end
        end
        if (string_bytes.size() > 0) begin
            idx = $urandom_range(0, string_bytes.size() - 1);
            if (mode >= 72 && mode < 80) begin
                // overwrite one byte
                string_bytes[idx].data    = 8'($urandom_range(0, 255));
                string_bytes[idx].present = 1'b1;
            end else if (mode >= 80 && mode < 86) begin
                // cut the tail, which often leaves a character open
                repeat ($urandom_range(1, 2))
                    if (string_bytes.size() > 0) void'(string_bytes.pop_back());
            end else if (mode >= 86 && mode < 92) begin
                string_bytes.insert(idx, '{data: 8'($urandom_range(0, 255)), present: 1'b1,
                                           last: 1'b0});
            end
        end
        end_string();
    endfunction

    initial begin
        int limits[NumPhases];
        int total;
        limits = '{64, 1, 255, 0, 3, 200, 64};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed strings at the reset limit
        send_item(8'h00, 1'b0, 1'b1);                 // empty string
        send_item(8'h5A, 1'b0, 1'b0);                 // no byte, not last: ignored
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b1);                 // ascii extremes
        send_item(8'hC2, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);                 // smallest two-byte character
        send_item(8'hF4, 1'b1, 1'b0);
        send_item(8'h8F, 1'b1, 1'b0);
        send_item(8'hBF, 1'b1, 1'b0);
        send_item(8'hBF, 1'b1, 1'b1);                 // largest code point
        send_item(8'hC1, 1'b1, 1'b1);                 // bad lead, overlong two-byte
        send_item(8'hFF, 1'b1, 1'b1);                 // bad lead, top byte
        send_item(8'hC2, 1'b1, 1'b0);
        send_item(8'h41, 1'b1, 1'b1);                 // bad continuation
        send_item(8'hE0, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);                 // overlong three-byte form
        send_item(8'hED, 1'b1, 1'b0);
        send_item(8'hA0, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);                 // surrogate
        send_item(8'hF4, 1'b1, 1'b0);
        send_item(8'h90, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);                 // above the top code point
        send_item(8'hE2, 1'b1, 1'b0);
        send_item(8'h82, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);                 // ends inside a character

        for (int ph = 0; ph < NumPhases; ph++) begin
            wait_drained();
            if (ph > 0) apb_access(1'b1, MaxCharsAddr, limits[ph]);
            apb_access(1'b0, MaxCharsAddr, '0);
            steady = (ph == 4);

            if (ph == 0) begin
                // receiver holds off while single-byte strings keep coming,
                // so the verdict buffer fills and input stalls
                rx_hold = 80;
                repeat (20) send_item(8'($urandom_range(0, 127)), 1'b1, 1'b1);
                // sender waits for every verdict before going on
                wait_drained();
            end

            if (limits[ph] == 255) begin
                // one string right at the limit and one just past it
                repeat (255) add_char(21'($urandom_range(0, 'h7F)), 1);
                end_string();
                send_string();
                repeat (256) add_char(21'($urandom_range(0, 'h7F)), 1);
                end_string();
                send_string();
            end

            while (bytes_sent < ByteTarget * (ph + 1) / NumPhases) begin
                build_random_string();
                send_string();
            end
        end

        // drain, then wait on for any stray verdicts
        s_tvalid <= 1'b0;
        while (sb.verdicts_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        total = 0;
        foreach (sb.reason_seen[i]) total += sb.reason_seen[i];
        $display("covered %0d strings in %0d byte transactions, limits 0 1 3 64 200 255",
                 total, bytes_sent);
        $display("verdicts ok %0d, lead %0d, continuation %0d, truncated %0d, point %0d, long %0d",
                 sb.reason_seen[utf8v_pkg::ERR_NONE], sb.reason_seen[utf8v_pkg::ERR_LEAD],
                 sb.reason_seen[utf8v_pkg::ERR_CONT], sb.reason_seen[utf8v_pkg::ERR_TRUNC],
                 sb.reason_seen[utf8v_pkg::ERR_POINT], sb.reason_seen[utf8v_pkg::ERR_LONG]);
        if (sb.errors == 0 && sb.verdicts_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
